// ===== rtl/ktdc_pkg.sv =====
// shared types, constants and key decode functions for the keypad tone/duty controller
`default_nettype none
package ktdc_pkg;

  localparam int KEY_W      = 16;
  localparam int SCAN_W     = 4;
  localparam int NOTE_IDX_W = 3;
  localparam int NOTE_W     = 4;
  localparam int PRESC_W    = 10;
  localparam int DUTY_W     = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam int STAR_BIT = 3;
  localparam int HASH_BIT = 11;

  localparam logic [NOTE_W-1:0]  NO_NOTE     = 4'd15;
  localparam logic [DUTY_W-1:0]  DUTY_RST    = 6'd9;
  localparam logic [DUTY_W-1:0]  DUTY_MAX_RST = 6'd19;
  localparam logic [PRESC_W-1:0] PRESC_RST   = 10'd5;

  localparam logic [KEY_W-1:0] NOTE_MASK = 16'h0377;

  localparam int QUEUE_DEPTH = 2;

  // register index on the config port
  localparam logic [0:0] REG_DUTY_MAX = 1'b0;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_NOTE = 2'd1,
    CLS_STAR = 2'd2,
    CLS_HASH = 2'd3
  } scan_class_t;

  typedef struct packed {
    scan_class_t           cls;
    logic [NOTE_IDX_W-1:0] note;
  } ktdc_event_t;

  // highest priority pressed note key
  function automatic logic [NOTE_IDX_W-1:0] note_index(input logic [KEY_W-1:0] keys);
    logic [NOTE_IDX_W-1:0] idx;
    idx = 3'd7;
    if (keys[0])      idx = 3'd0;
    else if (keys[1]) idx = 3'd1;
    else if (keys[2]) idx = 3'd2;
    else if (keys[4]) idx = 3'd3;
    else if (keys[5]) idx = 3'd4;
    else if (keys[6]) idx = 3'd5;
    else if (keys[8]) idx = 3'd6;
    return idx;
  endfunction

  function automatic logic [PRESC_W-1:0] note_prescaler(input logic [NOTE_IDX_W-1:0] idx);
    logic [PRESC_W-1:0] p;
    case (idx)
      3'd0:    p = 10'd763;
      3'd1:    p = 10'd571;
      3'd2:    p = 10'd403;
      3'd3:    p = 10'd679;
      3'd4:    p = 10'd509;
      3'd5:    p = 10'd381;
      3'd6:    p = 10'd605;
      default: p = 10'd453;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/keypad_tone_duty_controller.sv =====
// keypad tone/duty controller top level: config register, front, queue, back
// an item that ends a scan is written into the queue, then into the result register when popped
// throughput: one key sample per cycle while in_stall is low; front and back are split by a two-entry queue
// in_stall rises only while the queue is full, i.e. after the result side has stalled
// reset (synchronous, rst_n low): duty_max 19, duty 9, prescaler 5, tone off, no note
// the scan counter restarts at STABLE_SCANS and the queue and result register empty
`default_nettype none
module keypad_tone_duty_controller #(
  parameter int STABLE_SCANS = 5
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ktdc_pkg::KEY_W-1:0]          in_pressed_keys,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_scan_class,
  output logic [ktdc_pkg::PRESC_W-1:0]             out_tone_prescaler,
  output logic                                     out_tone_on,
  output logic [ktdc_pkg::DUTY_W-1:0]              out_duty_compare,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [ktdc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [ktdc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ktdc_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                     cfg_pready
);
  import ktdc_pkg::*;

  logic [DUTY_W-1:0] duty_max_r;
  logic              cfg_wr;
  logic [0:0]        reg_idx;
  logic              q_full;
  logic              q_push;
  ktdc_event_t       q_event;
  logic              q_pop;
  logic              q_head_valid;
  ktdc_event_t       q_head;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (reg_idx == REG_DUTY_MAX) ?
                      {{(CFG_DATA_W-DUTY_W){1'b0}}, duty_max_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_max_r <= DUTY_MAX_RST;
    end else if (cfg_wr && (reg_idx == REG_DUTY_MAX)) begin
      duty_max_r <= cfg_pwdata[DUTY_W-1:0];
    end
  end

  ktdc_front #(
    .STABLE_SCANS (STABLE_SCANS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pressed_keys (in_pressed_keys),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_event         (q_event)
  );

  ktdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_event),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  ktdc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .duty_max           (duty_max_r),
    .head_valid         (q_head_valid),
    .head_data          (q_head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_scan_class     (out_scan_class),
    .out_tone_prescaler (out_tone_prescaler),
    .out_tone_on        (out_tone_on),
    .out_duty_compare   (out_duty_compare)
  );

endmodule
`default_nettype wire

// ===== rtl/ktdc_front.sv =====
// front end: key sample classification and stable-scan counting
`default_nettype none
module ktdc_front #(
  parameter int STABLE_SCANS = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ktdc_pkg::KEY_W-1:0]  in_pressed_keys,
  input  wire logic                        q_full,
  output logic                             q_push,
  output ktdc_pkg::ktdc_event_t            q_event
);
  import ktdc_pkg::*;

  localparam logic [SCAN_W-1:0] SCANS_RST = SCAN_W'(STABLE_SCANS);

  logic [SCAN_W-1:0] scans_left_r, scans_left_nxt;
  logic [1:0]        prev_fk_r, prev_fk_nxt;
  logic              accept;
  logic              note_hit;
  logic [1:0]        fk;
  logic [SCAN_W-1:0] t;
  logic              done;
  scan_class_t       cls;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign note_hit = |(in_pressed_keys & NOTE_MASK);
  assign fk       = {in_pressed_keys[HASH_BIT], in_pressed_keys[STAR_BIT]};

  always_comb begin
    t = (fk != prev_fk_r) ? SCANS_RST : scans_left_r - 1'b1;
    scans_left_nxt = scans_left_r;
    prev_fk_nxt    = prev_fk_r;
    done           = 1'b0;
    cls            = CLS_NONE;
    if (note_hit) begin
      done = 1'b1;
      cls  = CLS_NOTE;
    end else begin
      done = (t == '0);
      if (fk[1])      cls = CLS_HASH;
      else if (fk[0]) cls = CLS_STAR;
      else            cls = CLS_NONE;
    end
    if (accept) begin
      if (done) begin
        scans_left_nxt = SCANS_RST;
        prev_fk_nxt    = 2'b00;
      end else begin
        scans_left_nxt = t;
        prev_fk_nxt    = fk;
      end
    end
  end

  assign q_push       = accept && done;
  assign q_event.cls  = cls;
  assign q_event.note = note_index(in_pressed_keys);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scans_left_r <= SCANS_RST;
      prev_fk_r    <= 2'b00;
    end else begin
      scans_left_r <= scans_left_nxt;
      prev_fk_r    <= prev_fk_nxt;
    end
  end

  a_scans_range: assert property (@(posedge clk) disable iff (!rst_n)
    (scans_left_r != '0) && (scans_left_r <= SCANS_RST))
    else $error("scan counter out of range");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (scans_left_r == SCANS_RST) && (prev_fk_r == 2'b00))
    else $error("scan not restarted after finish");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into full queue");

endmodule
`default_nettype wire

// ===== rtl/ktdc_queue.sv =====
// short event queue between front and back
`default_nettype none
module ktdc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire ktdc_pkg::ktdc_event_t push_data,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_valid,
  output ktdc_pkg::ktdc_event_t      head_data
);
  import ktdc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

  ktdc_event_t      mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == DEPTH_C);
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) || (count_r == DEPTH_C) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers inconsistent with count");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not drain queue");

endmodule
`default_nettype wire

// ===== rtl/ktdc_back.sv =====
// back end: tone and duty state update and result register
`default_nettype none
module ktdc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [ktdc_pkg::DUTY_W-1:0]   duty_max,
  input  wire logic                          head_valid,
  input  wire ktdc_pkg::ktdc_event_t         head_data,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_scan_class,
  output logic [ktdc_pkg::PRESC_W-1:0]       out_tone_prescaler,
  output logic                               out_tone_on,
  output logic [ktdc_pkg::DUTY_W-1:0]        out_duty_compare
);
  import ktdc_pkg::*;

  logic               key_held_r, key_held_nxt;
  logic [NOTE_W-1:0]  last_note_r, last_note_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic               tone_r, tone_nxt;
  logic [PRESC_W-1:0] presc_r, presc_nxt;
  logic               out_valid_r;
  logic [1:0]         out_cls_r;
  logic [PRESC_W-1:0] out_presc_r;
  logic               out_tone_r;
  logic [DUTY_W-1:0]  out_duty_r;
  logic [NOTE_W-1:0]  note_ext;

  assign pop      = head_valid && (!out_valid_r || !out_stall);
  assign note_ext = {1'b0, head_data.note};

  always_comb begin
    key_held_nxt  = key_held_r;
    last_note_nxt = last_note_r;
    duty_nxt      = duty_r;
    tone_nxt      = tone_r;
    presc_nxt     = presc_r;
    case (head_data.cls)
      CLS_NOTE: begin
        if (note_ext != last_note_r) begin
          presc_nxt = note_prescaler(head_data.note);
          tone_nxt  = 1'b1;
        end
        key_held_nxt  = 1'b1;
        last_note_nxt = note_ext;
      end
      CLS_STAR: begin
        if (!key_held_r && (duty_r != '0)) duty_nxt = duty_r - 1'b1;
        key_held_nxt = 1'b1;
      end
      CLS_HASH: begin
        if (!key_held_r && (duty_r < duty_max)) duty_nxt = duty_r + 1'b1;
        key_held_nxt = 1'b1;
      end
      default: begin
        tone_nxt      = 1'b0;
        key_held_nxt  = 1'b0;
        last_note_nxt = NO_NOTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_held_r  <= 1'b0;
      last_note_r <= NO_NOTE;
      duty_r      <= DUTY_RST;
      tone_r      <= 1'b0;
      presc_r     <= PRESC_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        key_held_r  <= key_held_nxt;
        last_note_r <= last_note_nxt;
        duty_r      <= duty_nxt;
        tone_r      <= tone_nxt;
        presc_r     <= presc_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_cls_r   <= head_data.cls;
      out_presc_r <= presc_nxt;
      out_tone_r  <= tone_nxt;
      out_duty_r  <= duty_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_scan_class     = out_cls_r;
  assign out_tone_prescaler = out_presc_r;
  assign out_tone_on        = out_tone_r;
  assign out_duty_compare   = out_duty_r;

  a_note_implies_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (last_note_r != NO_NOTE) |-> tone_r)
    else $error("note latched with tone off");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    !key_held_r |-> (last_note_r == NO_NOTE))
    else $error("note kept after release");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_duty_r == duty_r) && (out_tone_r == tone_r) && (out_presc_r == presc_r))
    else $error("result register differs from state");

endmodule
`default_nettype wire
